FILE: rtl/core/fmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmp_pkg;

    // Sysex frame buffer
    localparam int SYSEX_DEPTH = 64;
    localparam int SYSEX_AW    = $clog2(SYSEX_DEPTH);
    localparam int SYSEX_CW    = $clog2(SYSEX_DEPTH + 1);

    // Result field widths
    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 14;
    localparam int DATA_W  = 7;
    localparam int IDX_W   = 6;
    localparam int LEN_W   = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Whole-byte commands
    localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
    localparam logic [7:0] BYTE_VERSION      = 8'hF9;
    localparam logic [7:0] BYTE_SYSTEM_RESET = 8'hFF;
    localparam logic [7:0] BYTE_CHAN_LIMIT   = 8'hF0;

    // Channel commands, high nibble
    localparam logic [3:0] NIB_ANALOG         = 4'hE;
    localparam logic [3:0] NIB_DIGITAL        = 4'h9;
    localparam logic [3:0] NIB_REPORT_ANALOG  = 4'hC;
    localparam logic [3:0] NIB_REPORT_DIGITAL = 4'hD;

    typedef enum logic [2:0] {
        KIND_ANALOG  = 3'd0,
        KIND_DIGITAL = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_RESET   = 3'd3,
        KIND_SYSEX   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_ANALOG,
        PEND_DIGITAL,
        PEND_VERSION,
        PEND_REPORT
    } pending_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_DRAIN
    } back_state_t;

    // One classified transaction handed from front to back
    typedef struct packed {
        kind_t                 kind;
        logic [CHAN_W-1:0]     channel;
        logic [VALUE_W-1:0]    value;
        logic [SYSEX_CW-1:0]   length;
        logic                  resetting;
    } queue_entry_t;

    typedef struct packed {
        kind_t               kind;
        logic [CHAN_W-1:0]   channel;
        logic [VALUE_W-1:0]  value;
        logic [DATA_W-1:0]   payload_byte;
        logic [IDX_W-1:0]    byte_index;
        logic [LEN_W-1:0]    payload_length;
        logic                last;
        logic                resetting;
    } result_t;

    typedef struct packed {
        logic                en;
        logic [SYSEX_AW-1:0] addr;
        logic [DATA_W-1:0]   data;
    } ram_wr_t;

    typedef struct packed {
        logic                en;
        logic [SYSEX_AW-1:0] addr;
    } ram_rd_t;

endpackage

`default_nettype wire

FILE: rtl/core/fmp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fmp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fmp_result_if;
    import fmp_pkg::*;

    logic               valid;
    logic               ready;
    kind_t              kind;
    logic [CHAN_W-1:0]  channel;
    logic [VALUE_W-1:0] value;
    logic [DATA_W-1:0]  payload_byte;
    logic [IDX_W-1:0]   byte_index;
    logic [LEN_W-1:0]   payload_length;
    logic               last;
    logic               resetting;

    modport source (
        output valid, output kind, output channel, output value,
        output payload_byte, output byte_index, output payload_length,
        output last, output resetting,
        input  ready
    );
    modport sink (
        input  valid, input kind, input channel, input value,
        input  payload_byte, input byte_index, input payload_length,
        input  last, input resetting,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/firmata_message_parser_top.sv
// A byte that completes a command passes through the command queue into the output register.
// A sysex end byte passes through the queue and the registered read of the frame buffer; its run
// then gives one item per cycle as the sink takes them, paced by the registered buffer read.
// Throughput: one byte per cycle; input is held off from sysex end until the run's
// last item is loaded into the output register, and while the 2-entry queue is full.
// Reset (rst_n low, asynchronous): parser idle, results carry resetting 1; buffer not cleared.
`timescale 1ns / 1ps
`default_nettype none

module firmata_message_parser_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fmp_rx_if.sink       rx,
    fmp_result_if.source result
);
    import fmp_pkg::*;

    logic                push_valid, push_ready;
    queue_entry_t        push_entry;
    logic                pop_valid, pop_ready;
    queue_entry_t        pop_entry;
    ram_wr_t             ram_wr;
    ram_rd_t             ram_rd;
    logic [DATA_W-1:0]   rd_data;
    logic                drain_done;

    fmp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .q_valid    (push_valid),
        .q_ready    (push_ready),
        .q_entry    (push_entry),
        .ram_wr     (ram_wr),
        .drain_done (drain_done)
    );

    fmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    fmp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SYSEX_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.en),
        .rd_addr (ram_rd.addr),
        .rd_data (rd_data)
    );

    fmp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_entry    (pop_entry),
        .ram_rd     (ram_rd),
        .rd_data    (rd_data),
        .drain_done (drain_done),
        .result     (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/fmp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fmp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fmp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output      logic                  push_ready,
    input  wire fmp_pkg::queue_entry_t push_entry,
    output      logic                  pop_valid,
    input  wire logic                  pop_ready,
    output      fmp_pkg::queue_entry_t pop_entry
);
    import fmp_pkg::*;

    queue_entry_t         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fmp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fmp_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    fmp_rx_if.sink                     rx,
    output      logic                  q_valid,
    input  wire logic                  q_ready,
    output      fmp_pkg::queue_entry_t q_entry,
    output      fmp_pkg::ram_wr_t      ram_wr,
    input  wire logic                  drain_done
);
    import fmp_pkg::*;

    logic                 in_sysex_reg, in_sysex_next;
    logic [1:0]           awaited_reg, awaited_next;
    pending_t             pending_reg, pending_next;
    logic [CHAN_W-1:0]    channel_reg, channel_next;
    logic [DATA_W-1:0]    first_reg, first_next;
    logic [SYSEX_CW-1:0]  count_reg, count_next;
    logic                 reset_pending_reg, reset_pending_next;
    logic                 busy_reg, busy_next;
    logic                 accept;
    logic [7:0]           b;
    logic [VALUE_W-1:0]   data_value;

    // Hold off input while the queue is full or a sysex run still needs the buffer
    assign rx.ready   = q_ready && !busy_reg;
    assign accept     = rx.valid && rx.ready;
    assign b          = rx.rx_byte;
    assign data_value = {b[DATA_W-1:0], first_reg};

    // Classify the accepted byte
    always_comb
    begin
        in_sysex_next      = in_sysex_reg;
        awaited_next       = awaited_reg;
        pending_next       = pending_reg;
        channel_next       = channel_reg;
        first_next         = first_reg;
        count_next         = count_reg;
        reset_pending_next = reset_pending_reg;
        busy_next          = busy_reg;
        q_valid            = 1'b0;
        q_entry            = '0;
        q_entry.resetting  = reset_pending_reg;
        ram_wr             = '0;

        if (drain_done)
        begin
            busy_next = 1'b0;
        end

        if (accept)
        begin
            if (in_sysex_reg)
            begin
                if (b == BYTE_SYSEX_END)
                begin
                    in_sysex_next  = 1'b0;
                    busy_next      = 1'b1;
                    q_valid        = 1'b1;
                    q_entry.kind   = KIND_SYSEX;
                    q_entry.length = count_reg;
                end
                else if (b[7])
                begin
                    // drop frame on a stray command byte
                    in_sysex_next = 1'b0;
                end
                else if (count_reg == SYSEX_CW'(SYSEX_DEPTH))
                begin
                    // drop frame on overflow
                    in_sysex_next = 1'b0;
                end
                else
                begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = count_reg[SYSEX_AW-1:0];
                    ram_wr.data = b[DATA_W-1:0];
                    count_next  = count_reg + 1'b1;
                end
            end
            else if (awaited_reg != 2'd0)
            begin
                awaited_next = awaited_reg - 2'd1;
                if (awaited_reg == 2'd2)
                begin
                    first_next = b[DATA_W-1:0];
                end
                else
                begin
                    pending_next = PEND_NONE;
                    case (pending_reg)
                        PEND_ANALOG:
                        begin
                            q_valid         = 1'b1;
                            q_entry.kind    = KIND_ANALOG;
                            q_entry.channel = channel_reg;
                            q_entry.value   = data_value;
                        end
                        PEND_DIGITAL:
                        begin
                            q_valid         = 1'b1;
                            q_entry.kind    = KIND_DIGITAL;
                            q_entry.channel = channel_reg;
                            q_entry.value   = data_value;
                        end
                        PEND_VERSION:
                        begin
                            q_valid       = 1'b1;
                            q_entry.kind  = KIND_VERSION;
                            q_entry.value = data_value;
                        end
                        default: ;
                    endcase
                end
            end
            else if (b[7])
            begin
                if (b < BYTE_CHAN_LIMIT)
                begin
                    channel_next = b[3:0];
                    case (b[7:4])
                        NIB_ANALOG:
                        begin
                            awaited_next = 2'd2;
                            pending_next = PEND_ANALOG;
                        end
                        NIB_DIGITAL:
                        begin
                            awaited_next = 2'd2;
                            pending_next = PEND_DIGITAL;
                        end
                        NIB_REPORT_ANALOG, NIB_REPORT_DIGITAL:
                        begin
                            awaited_next = 2'd1;
                            pending_next = PEND_REPORT;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    case (b)
                        BYTE_VERSION:
                        begin
                            awaited_next = 2'd2;
                            pending_next = PEND_VERSION;
                        end
                        BYTE_SYSEX_START:
                        begin
                            in_sysex_next = 1'b1;
                            count_next    = '0;
                        end
                        BYTE_SYSTEM_RESET:
                        begin
                            reset_pending_next = 1'b0;
                            q_valid            = 1'b1;
                            q_entry.kind       = KIND_RESET;
                            q_entry.resetting  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sysex_reg      <= 1'b0;
            awaited_reg       <= 2'd0;
            pending_reg       <= PEND_NONE;
            channel_reg       <= '0;
            count_reg         <= '0;
            reset_pending_reg <= 1'b1;
            busy_reg          <= 1'b0;
        end
        else
        begin
            in_sysex_reg      <= in_sysex_next;
            awaited_reg       <= awaited_next;
            pending_reg       <= pending_next;
            channel_reg       <= channel_next;
            count_reg         <= count_next;
            reset_pending_reg <= reset_pending_next;
            busy_reg          <= busy_next;
        end
    end

    // First data byte of a two-byte command
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/fmp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fmp_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output      logic                  q_ready,
    input  wire fmp_pkg::queue_entry_t q_entry,
    output      fmp_pkg::ram_rd_t      ram_rd,
    input  wire logic [fmp_pkg::DATA_W-1:0] rd_data,
    output      logic                  drain_done,
    fmp_result_if.source               result
);
    import fmp_pkg::*;

    back_state_t          state_reg, state_next;
    logic [SYSEX_AW-1:0]  idx_reg, idx_next;
    logic [SYSEX_CW-1:0]  len_reg, len_next;
    logic                 res_reg, res_next;
    logic                 out_valid_reg;
    result_t              out_item_reg;
    logic                 slot_free;
    logic                 is_last;
    logic                 load;
    result_t              load_item;

    assign slot_free = !out_valid_reg || result.ready;
    assign is_last   = ((SYSEX_CW'(idx_reg) + SYSEX_CW'(1)) == len_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free && q_entry.kind == KIND_SYSEX && q_entry.length != '0)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (slot_free && is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Pop, buffer reads and output loads
    always_comb
    begin
        q_ready    = 1'b0;
        load       = 1'b0;
        load_item  = '0;
        ram_rd     = '0;
        drain_done = 1'b0;
        idx_next   = idx_reg;
        len_next   = len_reg;
        res_next   = res_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_ready             = 1'b1;
                    load_item.resetting = q_entry.resetting;
                    load_item.last      = 1'b1;
                    if (q_entry.kind != KIND_SYSEX)
                    begin
                        load              = 1'b1;
                        load_item.kind    = q_entry.kind;
                        load_item.channel = q_entry.channel;
                        load_item.value   = q_entry.value;
                    end
                    else if (q_entry.length == '0)
                    begin
                        // empty frame: one item, no buffer read
                        load           = 1'b1;
                        load_item.kind = KIND_SYSEX;
                        drain_done     = 1'b1;
                    end
                    else
                    begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = '0;
                        idx_next    = '0;
                        len_next    = q_entry.length;
                        res_next    = q_entry.resetting;
                    end
                end
            end
            BK_DRAIN:
            begin
                if (slot_free)
                begin
                    load                     = 1'b1;
                    load_item.kind           = KIND_SYSEX;
                    load_item.payload_byte   = rd_data;
                    load_item.byte_index     = IDX_W'(idx_reg);
                    load_item.payload_length = LEN_W'(len_reg);
                    load_item.last           = is_last;
                    load_item.resetting      = res_reg;
                    if (is_last)
                    begin
                        drain_done = 1'b1;
                    end
                    else
                    begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = idx_reg + 1'b1;
                        idx_next    = idx_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Run position and output payload
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        res_reg <= res_next;
        if (load)
        begin
            out_item_reg <= load_item;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_item_reg.kind;
    assign result.channel        = out_item_reg.channel;
    assign result.value          = out_item_reg.value;
    assign result.payload_byte   = out_item_reg.payload_byte;
    assign result.byte_index     = out_item_reg.byte_index;
    assign result.payload_length = out_item_reg.payload_length;
    assign result.last           = out_item_reg.last;
    assign result.resetting      = out_item_reg.resetting;

endmodule

`default_nettype wire

FILE: rtl/core/fmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fmp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire fmp_pkg::kind_t              kind,
    input wire logic [fmp_pkg::VALUE_W-1:0] value,
    input wire logic [fmp_pkg::IDX_W-1:0]   byte_index,
    input wire logic [fmp_pkg::LEN_W-1:0]   payload_length,
    input wire logic                        last,
    input wire logic                        resetting
);
    import fmp_pkg::*;

    // Stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(value)
            && $stable(byte_index) && $stable(last))
        else $error("result changed while stalled");

    // Non-sysex results are single items with no frame length
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_SYSEX |-> last && payload_length == '0)
        else $error("non-sysex result not a single item");

    // Position and last flag agree with frame length
    a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_SYSEX && payload_length != '0
            |-> (LEN_W'(byte_index) < payload_length)
                && (last == ((LEN_W'(byte_index) + LEN_W'(1)) == payload_length)))
        else $error("sysex index inconsistent with length");

    // Run items follow one another without gaps
    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && kind == KIND_SYSEX && !last
            |=> res_valid && kind == KIND_SYSEX
                && byte_index == IDX_W'($past(byte_index) + 1'b1))
        else $error("sysex run broken");

    // Resetting flag never comes back once cleared
    a_reset_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !resetting |=> !res_valid || !resetting)
        else $error("resetting flag set again");

endmodule

bind firmata_message_parser_top fmp_checker u_fmp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .kind           (result.kind),
    .value          (result.value),
    .byte_index     (result.byte_index),
    .payload_length (result.payload_length),
    .last           (result.last),
    .resetting      (result.resetting)
);

`default_nettype wire

FILE: tb/sv/firmata_message_parser_top_tb.sv
`timescale 1ns / 1ps

module firmata_message_parser_top_tb;
    import fmp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 380;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       src_valid = 1'b0;
    logic [7:0] src_byte = 8'h00;
    logic       sink_ready = 1'b0;

    int cycle_count = 0;
    int mismatch_count = 0;
    int burst_left = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_cycles = 0;

    // Parser state mirrored by the predictor
    logic                in_frame = 1'b0;
    logic [1:0]          data_left = 2'd0;
    pending_t            pend_cmd = PEND_NONE;
    logic [CHAN_W-1:0]   cmd_channel = '0;
    logic [DATA_W-1:0]   data_hold [2] = '{default: '0};
    logic [SYSEX_CW-1:0] frame_count = '0;
    logic [DATA_W-1:0]   frame_buf [SYSEX_DEPTH];
    logic                resetting_flag = 1'b1;

    result_t expected_msgs [$];
    result_t want_msg;

    fmp_rx_if     rx_ch ();
    fmp_result_if res_ch ();

    assign rx_ch.valid   = src_valid;
    assign rx_ch.rx_byte = src_byte;
    assign res_ch.ready  = sink_ready;

    firmata_message_parser_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("firmata_message_parser_top_tb failed");
            $finish;
        end
    end

    // Stall the result channel, switching pattern every so often
    always @(posedge clk)
    begin
        if (mode_cycles == 0)
        begin
            stall_mode  <= stall_mode_t'($urandom_range(0, 3));
            mode_cycles <= $urandom_range(20, 120);
        end
        else
        begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            STALL_NONE:     sink_ready <= 1'b1;
            STALL_LIGHT:    sink_ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY:    sink_ready <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: sink_ready <= ((cycle_count % 7) >= 2);
            default:        sink_ready <= 1'b1;
        endcase
    end

    function automatic void push_result(input kind_t k, input logic [CHAN_W-1:0] chan,
                                        input logic [VALUE_W-1:0] val,
                                        input logic [DATA_W-1:0] pbyte,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [LEN_W-1:0] len, input logic lst);
        result_t r;
        r.kind           = k;
        r.channel        = chan;
        r.value          = val;
        r.payload_byte   = pbyte;
        r.byte_index     = idx;
        r.payload_length = len;
        r.last           = lst;
        r.resetting      = resetting_flag;
        expected_msgs.push_back(r);
    endfunction

    // Advance the parser by one received byte and queue what it produces
    function automatic void decode_byte(input logic [7:0] b);
        int                 i;
        logic [VALUE_W-1:0] v;
        pending_t           pc;
        if (in_frame)
        begin
            if (b == BYTE_SYSEX_END)
            begin
                in_frame = 1'b0;
                if (frame_count == 0)
                begin
                    push_result(KIND_SYSEX, '0, '0, '0, '0, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < frame_count; i++)
                    begin
                        push_result(KIND_SYSEX, '0, '0, frame_buf[i], i[IDX_W-1:0],
                                    frame_count, (i + 1 == frame_count));
                    end
                end
            end
            else if (b[7] || frame_count >= SYSEX_DEPTH)
            begin
                // drop the frame silently
                in_frame = 1'b0;
            end
            else
            begin
                frame_buf[frame_count[SYSEX_AW-1:0]] = b[6:0];
                frame_count = frame_count + 1'b1;
            end
        end
        else if (data_left != 0)
        begin
            // every byte counts as data here, keep the low seven bits
            data_left = data_left - 1'b1;
            data_hold[data_left[0]] = b[6:0];
            if (data_left == 0)
            begin
                v = {data_hold[0], data_hold[1]};
                pc = pend_cmd;
                pend_cmd = PEND_NONE;
                case (pc)
                    PEND_ANALOG:  push_result(KIND_ANALOG, cmd_channel, v, '0, '0, '0, 1'b1);
                    PEND_DIGITAL: push_result(KIND_DIGITAL, cmd_channel, v, '0, '0, '0, 1'b1);
                    PEND_VERSION: push_result(KIND_VERSION, '0, v, '0, '0, '0, 1'b1);
                    default: ;
                endcase
            end
        end
        else if (b[7])
        begin
            if (b < BYTE_CHAN_LIMIT)
            begin
                cmd_channel = b[3:0];
                case (b[7:4])
                    NIB_ANALOG:
                    begin
                        data_left = 2'd2;
                        pend_cmd = PEND_ANALOG;
                    end
                    NIB_DIGITAL:
                    begin
                        data_left = 2'd2;
                        pend_cmd = PEND_DIGITAL;
                    end
                    NIB_REPORT_ANALOG, NIB_REPORT_DIGITAL:
                    begin
                        data_left = 2'd1;
                        pend_cmd = PEND_REPORT;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (b)
                    BYTE_VERSION:
                    begin
                        data_left = 2'd2;
                        pend_cmd = PEND_VERSION;
                    end
                    BYTE_SYSEX_START:
                    begin
                        in_frame = 1'b1;
                        frame_count = '0;
                    end
                    BYTE_SYSTEM_RESET:
                    begin
                        resetting_flag = 1'b0;
                        push_result(KIND_RESET, '0, '0, '0, '0, '0, 1'b1);
                    end
                    default: ;
                endcase
            end
        end
    endfunction

    function automatic void check_field(input string field_name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field_name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_msgs.size() == 0)
            begin
                $display("%0t: expected no result, got kind %0d value %0d byte %0d index %0d",
                         $time, res_ch.kind, res_ch.value, res_ch.payload_byte,
                         res_ch.byte_index);
                mismatch_count++;
            end
            else
            begin
                want_msg = expected_msgs.pop_front();
                check_field("kind", want_msg.kind, res_ch.kind);
                check_field("channel", want_msg.channel, res_ch.channel);
                check_field("value", want_msg.value, res_ch.value);
                check_field("payload_byte", want_msg.payload_byte, res_ch.payload_byte);
                check_field("byte_index", want_msg.byte_index, res_ch.byte_index);
                check_field("payload_length", want_msg.payload_length,
                            res_ch.payload_length);
                check_field("last", want_msg.last, res_ch.last);
                check_field("resetting", want_msg.resetting, res_ch.resetting);
            end
        end
    end

    // Send one byte transaction, idling between bursts
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        src_valid <= 1'b1;
        src_byte  <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        decode_byte(b);
    endtask

    function automatic logic [7:0] rand_data();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return {1'b0, 7'($urandom)};
    endfunction

    // Results before any system reset carry the resetting flag
    task automatic test_startup_flag();
        send_byte(8'hE3);
        send_byte(8'h05);
        send_byte(8'h7F);
    endtask

    // Hit channel and value extremes of analog and digital commands
    task automatic test_channel_extremes();
        send_byte({NIB_ANALOG, 4'h0});
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte({NIB_DIGITAL, 4'hF});
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // Version command whose data bytes have the top bit set
    task automatic test_version_data_wait();
        send_byte(BYTE_VERSION);
        send_byte(8'hFF);
        send_byte(8'h80);
    endtask

    // Reports give nothing, stray and unknown bytes are ignored
    task automatic test_report_and_ignored();
        send_byte({NIB_REPORT_ANALOG, 4'h4});
        send_byte(BYTE_VERSION);
        send_byte({NIB_REPORT_DIGITAL, 4'h1});
        send_byte(8'h01);
        send_byte(8'h42);
        send_byte(8'hA5);
    endtask

    task automatic test_system_reset();
        send_byte(BYTE_SYSTEM_RESET);
    endtask

    // Empty frame, a short frame, and a frame aborted by a command byte
    task automatic test_sysex_frames();
        send_byte(BYTE_SYSEX_START);
        send_byte(BYTE_SYSEX_END);
        send_byte(BYTE_SYSEX_START);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(BYTE_SYSEX_END);
        send_byte(BYTE_SYSEX_START);
        send_byte(8'h11);
        send_byte(8'h85);
    endtask

    // Mostly well-formed messages with random content, plus noise
    task automatic test_random_traffic();
        int         sent;
        int         pick;
        int         len;
        int         sel;
        logic [7:0] b;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
            begin
                send_byte({NIB_ANALOG, 4'($urandom)});
                send_byte(rand_data());
                send_byte(rand_data());
                sent += 3;
            end
            else if (pick < 34)
            begin
                send_byte({NIB_DIGITAL, 4'($urandom)});
                send_byte(rand_data());
                send_byte(rand_data());
                sent += 3;
            end
            else if (pick < 42)
            begin
                send_byte(BYTE_VERSION);
                send_byte(rand_data());
                send_byte(rand_data());
                sent += 3;
            end
            else if (pick < 52)
            begin
                send_byte({($urandom_range(0, 1) != 0) ? NIB_REPORT_ANALOG : NIB_REPORT_DIGITAL,
                           4'($urandom)});
                send_byte(rand_data());
                sent += 2;
            end
            else if (pick < 55)
            begin
                send_byte(BYTE_SYSTEM_RESET);
                sent += 1;
            end
            else if (pick < 82)
            begin
                // keep most frames short, a few full, one short of full or one past full
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    len = $urandom_range(0, 6);
                else if (sel < 80)
                    len = $urandom_range(7, 40);
                else if (sel < 90)
                    len = SYSEX_DEPTH;
                else if (sel < 95)
                    len = SYSEX_DEPTH - 1;
                else
                    len = SYSEX_DEPTH + 1;
                send_byte(BYTE_SYSEX_START);
                repeat (len) send_byte({1'b0, 7'($urandom)});
                if ($urandom_range(0, 9) == 0)
                begin
                    b = 8'($urandom_range(8'h80, 8'hFF));
                    if (b == BYTE_SYSEX_END)
                        b = BYTE_SYSEX_START;
                    send_byte(b);
                end
                else
                begin
                    send_byte(BYTE_SYSEX_END);
                end
                sent += len + 2;
            end
            else if (pick < 90)
            begin
                send_byte(8'($urandom_range(8'h80, 8'hFF)));
                sent += 1;
            end
            else
            begin
                send_byte(8'($urandom));
                sent += 1;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_startup_flag();
        test_channel_extremes();
        test_version_data_wait();
        test_report_and_ignored();
        test_system_reset();
        test_sysex_frames();
        test_random_traffic();

        // Hold the input idle and let the last results drain
        src_valid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("firmata_message_parser_top_tb passed");
        else
            $display("firmata_message_parser_top_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fmp_pkg.sv
rtl/core/fmp_if.sv
rtl/core/fmp_ram.sv
rtl/core/fmp_queue.sv
rtl/core/fmp_front.sv
rtl/core/fmp_back.sv
rtl/core/firmata_message_parser_top.sv
rtl/core/fmp_checker.sv
tb/sv/firmata_message_parser_top_tb.sv
